FILE: rtl/cvef_pkg.sv
// shared types and constants for the vertical edge filter core
`default_nettype none

package cvef_pkg;

    // register field widths
    localparam int FW_REG_W = 11;
    localparam int FH_REG_W = 13;
    localparam int CC_REG_W = 3;

    // register reset values
    localparam logic [FW_REG_W-1:0] FRAME_WIDTH_RST   = 11'd640;
    localparam logic [FH_REG_W-1:0] FRAME_HEIGHT_RST  = 13'd480;
    localparam logic [CC_REG_W-1:0] CHANNEL_COUNT_RST = 3'd3;

    // frame geometry limits
    localparam int HEIGHT_LIMIT = 4096;
    localparam int ROW_W        = 12;

    // arithmetic
    localparam int PIX_W   = 8;
    localparam int PIX_MAX = 255;
    localparam int SUM_W   = 12;

    // apb port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [FW_REG_W-1:0] frame_width;
        logic [FH_REG_W-1:0] frame_height;
        logic [CC_REG_W-1:0] channel_count;
    } cfg_t;

    // which window borders fall outside the frame for the output pixel
    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } border_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_extra;
        logic             frame_end;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/cvef_if.sv
// stream interfaces for pixel input and filtered result output
`default_nettype none

interface cvef_pix_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_extra;

    modport source (output valid, mode, in_red, in_green, in_blue, in_extra, input ready);
    modport sink   (input valid, mode, in_red, in_green, in_blue, in_extra, output ready);
endinterface

interface cvef_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_extra;
    logic       frame_end;

    modport source (output valid, out_red, out_green, out_blue, out_extra, frame_end,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_extra, frame_end,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/conv3x3_vertical_edge_filter_core.sv
// top level of the 3x3 vertical edge filter over a raster pixel stream
//
//  channel  | role                       | handshake
//  ---------+----------------------------+------------------------------
//  pixel    | pixels and flush ticks in  | valid/ready, interface sink
//  result   | filtered pixels out        | valid/ready, interface source
//  apb      | geometry/channel registers | psel/penable, pready tied high
//
// one transaction per clock on the pixel side; a result leaves width+1 pixels
// after its centre pixel enters, in the cycle after the transaction that emits it.
// the row stores are read ahead at the next column, so every pixel
// finds its column ready in the read registers; a two-entry result queue sets
// pixel ready, which drops only while both entries wait on the result side.
// reset clears positions, counters, window and queue; row stores are not cleared.
`default_nettype none

module conv3x3_vertical_edge_filter_core #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    cvef_pix_if.sink                             pixel,
    cvef_res_if.source                           result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cvef_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [cvef_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [cvef_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int FW    = $clog2(MAX_WIDTH + 3);
    localparam int WC    = (FW > cvef_pkg::FW_REG_W) ? FW : cvef_pkg::FW_REG_W;
    localparam int RW    = cvef_pkg::ROW_W;
    localparam int HW    = cvef_pkg::FH_REG_W;
    localparam int NCH   = MAX_CHANNELS;
    localparam int PXW   = 8 * NCH;

    typedef logic [NCH-1:0][7:0] px_t;

    cvef_pkg::cfg_t    cfg;
    cvef_pkg::border_t border;
    cvef_pkg::result_t res;

    logic [FW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [cvef_pkg::CC_REG_W-1:0] nch_eff;
    logic [WC-1:0] w_raw;

    logic [RW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [FW-1:0] fill_reg, fill_next, fill_after;
    logic [FW-1:0] pad_reg, pad_next, pad_after;
    logic [2:0][2:0][NCH-1:0][7:0] win_reg, win_next;

    logic [RW+CW-1:0] in_adv, out_adv;
    logic [3:0][7:0]  in_all;
    px_t              push_px;
    px_t              near_rd, far_rd;
    logic [2:0][NCH-1:0][7:0] col_px;
    logic [2:0][NCH-1:0][7:0] plus_px;

    logic accept, push, emit, drain_done, fifo_full;

    // configuration registers
    cvef_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // effective geometry and channel count
    always_comb
    begin
        w_raw = WC'(cfg.frame_width);
        if (w_raw == '0)
            w_eff = FW'(1);
        else if (w_raw > WC'(MAX_WIDTH))
            w_eff = FW'(MAX_WIDTH);
        else
            w_eff = w_raw[FW-1:0];

        if (cfg.frame_height == '0)
            h_eff = HW'(1);
        else if (cfg.frame_height > HW'(cvef_pkg::HEIGHT_LIMIT))
            h_eff = HW'(cvef_pkg::HEIGHT_LIMIT);
        else
            h_eff = cfg.frame_height;

        if (cfg.channel_count == '0)
            nch_eff = cvef_pkg::CC_REG_W'(1);
        else if (cfg.channel_count > cvef_pkg::CC_REG_W'(MAX_CHANNELS))
            nch_eff = cvef_pkg::CC_REG_W'(MAX_CHANNELS);
        else
            nch_eff = cfg.channel_count;
    end

    // raster position step with row and frame wrap
    function automatic logic [RW+CW-1:0] advance(
        input logic [RW-1:0] row,
        input logic [CW-1:0] col,
        input logic [FW-1:0] w,
        input logic [HW-1:0] h
    );
        logic [RW-1:0] row_n;
        logic [CW-1:0] col_n;
        row_n = row;
        col_n = col + CW'(1);
        if ((FW'(col) + FW'(1)) >= w)
        begin
            col_n = '0;
            if ((HW'(row) + HW'(1)) >= h)
                row_n = '0;
            else
                row_n = row + RW'(1);
        end
        return {row_n, col_n};
    endfunction

    assign in_adv  = advance(in_row_reg, in_col_reg, w_eff, h_eff);
    assign out_adv = advance(out_row_reg, out_col_reg, w_eff, h_eff);

    // transaction control
    assign accept  = pixel.valid && pixel.ready;
    assign pixel.ready = !fifo_full;
    assign push    = accept && (!pixel.mode || (fill_reg > pad_reg));
    assign emit    = push && (fill_reg > w_eff);

    always_comb
    begin
        fill_after = emit ? fill_reg : fill_reg + FW'(1);
        pad_after  = pixel.mode ? pad_reg + FW'(1) : '0;
        drain_done = push && pixel.mode && (fill_after <= pad_after);

        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (emit)
            {out_row_next, out_col_next} = out_adv;

        fill_next   = fill_reg;
        pad_next    = pad_reg;
        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        if (push)
        begin
            fill_next = fill_after;
            pad_next  = pad_after;
            {in_row_next, in_col_next} = in_adv;
            if (drain_done)
            begin
                fill_next   = '0;
                pad_next    = '0;
                in_row_next = out_row_next;
                in_col_next = out_col_next;
            end
        end
    end

    // incoming pixel, zero on flush
    assign in_all  = {pixel.in_extra, pixel.in_blue, pixel.in_green, pixel.in_red};
    assign push_px = pixel.mode ? px_t'('0) : in_all[NCH-1:0];

    // row stores, read ahead at the next input column
    cvef_line_mem #(.DEPTH(MAX_WIDTH), .DATA_W(PXW)) u_near (
        .clk   (clk),
        .we    (push),
        .waddr (in_col_reg),
        .wdata (push_px),
        .raddr (in_col_next),
        .rdata (near_rd)
    );

    cvef_line_mem #(.DEPTH(MAX_WIDTH), .DATA_W(PXW)) u_far (
        .clk   (clk),
        .we    (push),
        .waddr (in_col_reg),
        .wdata (near_rd),
        .raddr (in_col_next),
        .rdata (far_rd)
    );

    assign col_px = {push_px, near_rd, far_rd};

    // window shift
    always_comb
    begin
        win_next = win_reg;
        if (push)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
                win_next[r][2] = col_px[r];
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            fill_reg    <= '0;
            pad_reg     <= '0;
            win_reg     <= '0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            fill_reg    <= fill_next;
            pad_reg     <= pad_next;
            win_reg     <= win_next;
        end
    end

    // borders of the output pixel
    assign border.left   = (out_col_reg == '0);
    assign border.right  = ((FW'(out_col_reg) + FW'(1)) >= w_eff);
    assign border.top    = (out_row_reg == '0);
    assign border.bottom = ((HW'(out_row_reg) + HW'(1)) >= h_eff);

    // left taps are the pre-shift middle column, right taps the entering column
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            plus_px[r] = win_reg[r][1];
        end
    end

    cvef_filter #(.NCH(NCH)) u_filter (
        .plus_px   (plus_px),
        .minus_px  (col_px),
        .centre_px (win_reg[1][2]),
        .border    (border),
        .nch       (nch_eff),
        .res       (res)
    );

    // result queue
    cvef_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (res),
        .full      (fifo_full),
        .result    (result)
    );

`ifndef SYNTHESIS
    // flush padding never outnumbers pending pixels
    a_pad_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
        pad_reg <= fill_reg)
        else $error("flush pad count exceeds pending count");

    // an emitted result is visible on the result side next cycle
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> result.valid)
        else $error("emitted result not presented");

    // after the drain completes the input position catches up with the output
    a_drain_sync: assert property (@(posedge clk) disable iff (!rst_n)
        drain_done |=> (in_row_reg == out_row_reg) && (in_col_reg == out_col_reg))
        else $error("positions differ after drain");
`endif

endmodule

`default_nettype wire

FILE: rtl/cvef_cfg_regs.sv
// apb configuration registers for frame geometry and channel count
`default_nettype none

module cvef_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cvef_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [cvef_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [cvef_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output cvef_pkg::cfg_t                         cfg
);

    cvef_pkg::cfg_t   cfg_reg;
    cvef_pkg::cfg_t   cfg_next;
    cvef_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = cvef_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                cvef_pkg::REG_FRAME_WIDTH:
                    cfg_next.frame_width = pwdata[cvef_pkg::FW_REG_W-1:0];
                cvef_pkg::REG_FRAME_HEIGHT:
                    cfg_next.frame_height = pwdata[cvef_pkg::FH_REG_W-1:0];
                cvef_pkg::REG_CHANNEL_COUNT:
                    cfg_next.channel_count = pwdata[cvef_pkg::CC_REG_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width   <= cvef_pkg::FRAME_WIDTH_RST;
            cfg_reg.frame_height  <= cvef_pkg::FRAME_HEIGHT_RST;
            cfg_reg.channel_count <= cvef_pkg::CHANNEL_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            cvef_pkg::REG_FRAME_WIDTH:   prdata = cvef_pkg::APB_DATA_W'(cfg_reg.frame_width);
            cvef_pkg::REG_FRAME_HEIGHT:  prdata = cvef_pkg::APB_DATA_W'(cfg_reg.frame_height);
            cvef_pkg::REG_CHANNEL_COUNT: prdata = cvef_pkg::APB_DATA_W'(cfg_reg.channel_count);
            default:                     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/cvef_line_mem.sv
// one row store: single write port, registered read with write bypass
`default_nettype none

module cvef_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    // storage write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, new data forwarded on a same-address write
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cvef_filter.sv
// kernel sums with border masking, clamp and channel selection
`default_nettype none

module cvef_filter #(
    parameter int NCH = 4
) (
    input  wire logic [2:0][NCH-1:0][7:0]         plus_px,
    input  wire logic [2:0][NCH-1:0][7:0]         minus_px,
    input  wire logic [NCH-1:0][7:0]              centre_px,
    input  wire cvef_pkg::border_t                border,
    input  wire logic [cvef_pkg::CC_REG_W-1:0]    nch,
    output cvef_pkg::result_t                     res
);

    logic [2:0][7:0] filt;
    logic [2:0]      row_en;

    // rows above or below the frame are zero padding
    assign row_en = {!border.bottom, 1'b1, !border.top};

    for (genvar k = 0; k < 3; k++)
    begin : g_chan
        if (k < NCH)
        begin : g_live
            logic signed [cvef_pkg::SUM_W-1:0] sum;

            // three-row column difference
            always_comb
            begin
                sum = '0;
                for (int r = 0; r < 3; r++)
                begin
                    if (row_en[r])
                    begin
                        if (!border.left)
                            sum = sum + signed'(cvef_pkg::SUM_W'(plus_px[r][k]));
                        if (!border.right)
                            sum = sum - signed'(cvef_pkg::SUM_W'(minus_px[r][k]));
                    end
                end
            end

            // clamp to pixel range, blank unused channels
            always_comb
            begin
                if (cvef_pkg::CC_REG_W'(k) >= nch)
                    filt[k] = '0;
                else if (sum < 0)
                    filt[k] = '0;
                else if (sum > cvef_pkg::SUM_W'(cvef_pkg::PIX_MAX))
                    filt[k] = 8'(cvef_pkg::PIX_MAX);
                else
                    filt[k] = sum[7:0];
            end
        end
        else
        begin : g_none
            assign filt[k] = '0;
        end
    end

    // fourth channel copied from the centre pixel
    if (NCH >= 4)
    begin : g_extra
        assign res.out_extra = (nch >= cvef_pkg::CC_REG_W'(4)) ? centre_px[3] : '0;
    end
    else
    begin : g_no_extra
        assign res.out_extra = '0;
    end

    assign res.out_red   = filt[0];
    assign res.out_green = filt[1];
    assign res.out_blue  = filt[2];
    assign res.frame_end = border.bottom && border.right;

endmodule

`default_nettype wire

FILE: rtl/cvef_out_fifo.sv
// two-entry result queue decoupling the pixel side from the result side
`default_nettype none

module cvef_out_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire cvef_pkg::result_t push_data,
    output logic                   full,
    cvef_res_if.source             result
);

    cvef_pkg::result_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop  = result.valid && result.ready;
    assign full = (count_reg == 2'd2);

    // pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign result.valid     = (count_reg != 2'd0);
    assign result.out_red   = slot_reg[rd_ptr_reg].out_red;
    assign result.out_green = slot_reg[rd_ptr_reg].out_green;
    assign result.out_blue  = slot_reg[rd_ptr_reg].out_blue;
    assign result.out_extra = slot_reg[rd_ptr_reg].out_extra;
    assign result.frame_end = slot_reg[rd_ptr_reg].frame_end;

endmodule

`default_nettype wire
